[src/length_prefixed_unit_deframer_top_defines.svh]
// Assertion macros shared by the deframer RTL.
// No dependencies; define ASSERT_OFF to drop all checks.
`ifndef LENGTH_PREFIXED_UNIT_DEFRAMER_TOP_DEFINES_SVH
`define LENGTH_PREFIXED_UNIT_DEFRAMER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define LPUD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LPUD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LPUD_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define LPUD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[src/lpud_pkg.sv]
// Types and constants of the length-prefixed unit deframer.
// No dependencies; used by every module of the block.
package lpud_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned ULEN_W    = 25;
   localparam int unsigned LEN_ACC_W = 32;

   localparam logic [ULEN_W-1:0] HARD_LIMIT = 25'h1000000;

   localparam logic [3:0] HDR_LAST_POS = 4'd10;
   localparam logic [3:0] MAGIC_BYTES  = 4'd4;
   localparam logic [3:0] LEN_LAST_POS = 4'd3;

   localparam logic [7:0] VERSION_ONE = 8'h01;
   localparam logic [7:0] CODEC_HEVC  = 8'h02;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_START   = 2'd1;
   localparam logic [1:0] KIND_PAYLOAD = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   localparam logic [1:0] ERR_MAGIC   = 2'd0;
   localparam logic [1:0] ERR_VERSION = 2'd1;
   localparam logic [1:0] ERR_LENGTH  = 2'd2;

   typedef enum logic [3:0] {
      PH_HEADER  = 4'b0001,
      PH_LENGTH  = 4'b0010,
      PH_PAYLOAD = 4'b0100,
      PH_HALTED  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic              valid;
      logic [1:0]        kind;
      logic [7:0]        out_byte;
      logic [7:0]        codec_id;
      logic              codec_is_hevc;
      logic [15:0]       frame_width;
      logic [15:0]       frame_height;
      logic [7:0]        frame_rate;
      logic [ULEN_W-1:0] unit_length;
      logic [1:0]        fault_code;
      logic              last_of_unit;
   } result_type;

   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] val;
      case (idx)
         2'd0:    val = 8'h56;
         2'd1:    val = 8'h43;
         2'd2:    val = 8'h4D;
         2'd3:    val = 8'h44;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

[src/lpud_parser.sv]
// Stream parser: header check, length assembly and payload count.
// Depends on lpud_pkg and the deframer assertion macros.
`include "length_prefixed_unit_deframer_top_defines.svh"

module lpud_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [24:0]            csr_wr_data,
   input  logic                   accept,
   input  logic [7:0]             data_byte,
   output lpud_pkg::result_type   res_in
);
   import lpud_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [3:0]             pos_ff, pos_in;
   logic                   magic_ok_ff, magic_ok_in;
   logic [47:0]            hdr_ff, hdr_in;
   logic [LEN_ACC_W-1:0]   remain_ff, remain_in;
   logic [ULEN_W-1:0]      max_len_ff;
   logic [ULEN_W-1:0]      limit;
   logic [LEN_ACC_W-1:0]   len_next;

   assign limit    = (max_len_ff > HARD_LIMIT) ? HARD_LIMIT : max_len_ff;
   assign len_next = {remain_ff[LEN_ACC_W-BYTE_W-1:0], data_byte};

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      magic_ok_in = magic_ok_ff;
      hdr_in      = hdr_ff;
      remain_in   = remain_ff;
      res_in      = '0;
      case (phase_ff)
         PH_HEADER: begin
            if (pos_ff < MAGIC_BYTES) begin
               if (data_byte != magic_byte(pos_ff[1:0])) magic_ok_in = 1'b0;
            end else if (pos_ff < HDR_LAST_POS) begin
               hdr_in = {hdr_ff[39:0], data_byte};
            end
            if (pos_ff < HDR_LAST_POS) begin
               pos_in = pos_ff + 4'd1;
            end else if (!magic_ok_ff) begin
               res_in.valid      = 1'b1;
               res_in.kind       = KIND_ERROR;
               res_in.fault_code = ERR_MAGIC;
               phase_in          = PH_HALTED;
            end else if (hdr_ff[47:40] != VERSION_ONE) begin
               res_in.valid      = 1'b1;
               res_in.kind       = KIND_ERROR;
               res_in.fault_code = ERR_VERSION;
               phase_in          = PH_HALTED;
            end else begin
               res_in.valid         = 1'b1;
               res_in.kind          = KIND_HEADER;
               res_in.codec_id      = hdr_ff[39:32];
               res_in.codec_is_hevc = (hdr_ff[39:32] == CODEC_HEVC);
               res_in.frame_width   = hdr_ff[31:16];
               res_in.frame_height  = hdr_ff[15:0];
               res_in.frame_rate    = data_byte;
               phase_in             = PH_LENGTH;
               pos_in               = '0;
               remain_in            = '0;
            end
         end
         PH_LENGTH: begin
            remain_in = len_next;
            if (pos_ff < LEN_LAST_POS) begin
               pos_in = pos_ff + 4'd1;
            end else begin
               pos_in = '0;
               if (len_next == '0 || len_next > {{(LEN_ACC_W-ULEN_W){1'b0}}, limit}) begin
                  res_in.valid      = 1'b1;
                  res_in.kind       = KIND_ERROR;
                  res_in.fault_code = ERR_LENGTH;
                  phase_in          = PH_HALTED;
               end else begin
                  res_in.valid       = 1'b1;
                  res_in.kind        = KIND_START;
                  res_in.unit_length = len_next[ULEN_W-1:0];
                  phase_in           = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            res_in.valid    = 1'b1;
            res_in.kind     = KIND_PAYLOAD;
            res_in.out_byte = data_byte;
            if (remain_ff <= 32'd1) begin
               res_in.last_of_unit = 1'b1;
               remain_in           = '0;
               pos_in              = '0;
               phase_in            = PH_LENGTH;
            end else begin
               remain_in = remain_ff - 32'd1;
            end
         end
         PH_HALTED: begin
            phase_in = PH_HALTED;
         end
         default: begin
            phase_in = PH_HALTED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         pos_ff      <= '0;
         magic_ok_ff <= 1'b1;
         hdr_ff      <= '0;
         remain_ff   <= '0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         magic_ok_ff <= magic_ok_in;
         hdr_ff      <= hdr_in;
         remain_ff   <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= HARD_LIMIT;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   `LPUD_ASSERT_IMPL(a_halted_silent, clock, reset, phase_ff == PH_HALTED, !res_in.valid, "result while halted")
   `LPUD_ASSERT_NEXT(a_error_halts, clock, reset, accept && res_in.valid && res_in.kind == KIND_ERROR, phase_ff == PH_HALTED, "error did not halt")
   `LPUD_ASSERT_IMPL(a_payload_nonzero, clock, reset, phase_ff == PH_PAYLOAD, remain_ff != '0, "payload phase with zero count")
   `LPUD_ASSERT_NEXT(a_start_loads, clock, reset, accept && res_in.valid && res_in.kind == KIND_START, phase_ff == PH_PAYLOAD && remain_ff[ULEN_W-1:0] == $past(res_in.unit_length), "start code count mismatch")

endmodule

[src/lpud_out_reg.sv]
// Result register between parser and the rsp_ channel.
// Depends on lpud_pkg.
module lpud_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  lpud_pkg::result_type res_in,
   input  logic                 rsp_ready,
   output logic                 take_ok,
   output logic                 rsp_valid,
   output lpud_pkg::result_type res_out
);
   import lpud_pkg::*;

   logic       valid_ff;
   result_type data_ff;

   assign take_ok   = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign res_out   = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take_ok) begin
         valid_ff <= load && res_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take_ok && load && res_in.valid) begin
         data_ff <= res_in;
      end
   end

endmodule

[src/length_prefixed_unit_deframer_top.sv]
// Length-prefixed unit deframer, top level.
// The parser state updates in a single pass; its result is registered
// and shows in the next cycle; one word per cycle unless rsp_ready stalls.
// Reset (synchronous, active high): header phase, limit register 16777216,
// result register empty.
module length_prefixed_unit_deframer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [24:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_out_byte,
   output logic [7:0]  rsp_codec_id,
   output logic        rsp_codec_is_hevc,
   output logic [15:0] rsp_frame_width,
   output logic [15:0] rsp_frame_height,
   output logic [7:0]  rsp_frame_rate,
   output logic [24:0] rsp_unit_length,
   output logic [1:0]  rsp_fault_code,
   output logic        rsp_last_of_unit
);
   import lpud_pkg::*;

   result_type res_in;
   result_type res_out;
   logic       accept;
   logic       take_ok;

   assign req_ready = take_ok;
   assign accept    = req_valid && take_ok;

   lpud_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .data_byte   (req_data_byte),
      .res_in      (res_in)
   );

   lpud_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .res_in    (res_in),
      .rsp_ready (rsp_ready),
      .take_ok   (take_ok),
      .rsp_valid (rsp_valid),
      .res_out   (res_out)
   );

   assign rsp_kind          = res_out.kind;
   assign rsp_out_byte      = res_out.out_byte;
   assign rsp_codec_id      = res_out.codec_id;
   assign rsp_codec_is_hevc = res_out.codec_is_hevc;
   assign rsp_frame_width   = res_out.frame_width;
   assign rsp_frame_height  = res_out.frame_height;
   assign rsp_frame_rate    = res_out.frame_rate;
   assign rsp_unit_length   = res_out.unit_length;
   assign rsp_fault_code    = res_out.fault_code;
   assign rsp_last_of_unit  = res_out.last_of_unit;

endmodule
